/* design/hdlcrx_pkg.sv */
// Shared constants, types and CRC helpers for the HDLC receive deframer.
// No dependencies; compiled first.
package hdlcrx_pkg;

  // Field and counter widths
  localparam int BYTE_W  = 8;
  localparam int POS_W   = 12;
  localparam int LEN_W   = 12;
  localparam int MAXL_W  = 12;
  localparam int CRC_W   = 16;
  localparam int CNT_W   = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [POS_W-1:0] POS_MASK = {POS_W{1'b1}};

  // Line octets
  localparam logic [BYTE_W-1:0] FLAG_OCTET = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_OCTET  = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR    = 8'h20;
  // Five ones followed by the newest bit: a stuffed zero to drop
  localparam logic [BYTE_W-1:0] STUFF_MASK = 8'hFC;
  localparam logic [BYTE_W-1:0] STUFF_PAT  = 8'h7C;

  localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

  // Register reset values
  localparam logic              MODE_RST     = 1'b0;
  localparam logic              HIFIRST_RST  = 1'b0;
  localparam logic [MAXL_W-1:0] MAX_LEN_RST  = 12'd1000;
  localparam logic [CRC_W-1:0]  CRC_INIT_RST = 16'hFFFF;

  // Register indexes (word address)
  localparam logic [1:0] REG_BITWISE_MODE   = 2'd0;
  localparam logic [1:0] REG_CRC_HIGH_FIRST = 2'd1;
  localparam logic [1:0] REG_MAX_FRAME_LEN  = 2'd2;
  localparam logic [1:0] REG_CRC_INIT       = 2'd3;

  // End-of-frame status codes
  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_CRC_ERR  = 2'd1,
    ST_TOO_LONG = 2'd2
  } frame_status_t;

  // One entry of the byte-wise CRC-16 table (MSB first, poly 0x1021)
  function automatic logic [CRC_W-1:0] crc_tbl(input logic [BYTE_W-1:0] idx);
    logic [CRC_W-1:0] c;
    c = {idx, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    return c;
  endfunction

  // Fold one byte into the running CRC
  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0]  crc,
                                                input logic [BYTE_W-1:0] v);
    return {crc[7:0], 8'h00} ^ crc_tbl(crc[15:8] ^ v);
  endfunction

endpackage

/* design/hdlcrx_in_if.sv */
// Input channel of the HDLC receive deframer: valid/ready plus one line symbol.
// Depends on hdlcrx_pkg.
interface hdlcrx_in_if;
  logic                           valid;
  logic                           ready;
  logic [hdlcrx_pkg::BYTE_W-1:0]  data_in;

  modport source (output valid, output data_in, input ready);
  modport sink   (input valid, input data_in, output ready);
endinterface

/* design/hdlcrx_out_if.sv */
// Result channel of the HDLC receive deframer: payload bytes and frame status.
// Depends on hdlcrx_pkg.
interface hdlcrx_out_if;
  logic                           valid;
  logic                           ready;
  logic [hdlcrx_pkg::BYTE_W-1:0]  out_byte;
  logic                           frame_end;
  logic [1:0]                     frame_status;
  logic [hdlcrx_pkg::LEN_W-1:0]   payload_len;

  modport source (output valid, output out_byte, output frame_end,
                  output frame_status, output payload_len, input ready);
  modport sink   (input valid, input out_byte, input frame_end,
                  input frame_status, input payload_len, output ready);
endinterface

/* design/hdlc_receive_deframer.sv */
// HDLC receive deframer top level: bit destuffing, escape removal, CRC-16 check.
// Depends on hdlcrx_pkg, hdlcrx_in_if and hdlcrx_out_if.
//
// Usage:
//   in_ch  : line symbols, one octet per request (byte mode) or one line bit in
//            data_in[0], LSB of each octet first (bit mode).
//   out_ch : payload bytes (frame_end = 0) and one end-of-frame status request
//            per frame of two or more octets (frame_end = 1, frame_status, payload_len).
//   APB    : registers bitwise_mode, crc_high_first, max_frame_len, crc_init at
//            byte addresses 0, 4, 8, 12. Write them only while the block is idle.
// Timing: a symbol accepted into the input register is decoded from there and
//   its result (if any) is written into the output register once that register
//   can take it. One symbol is taken every cycle while out_ch is not held off. The
//   decode, the CRC table step and the frame-length compare are combinational.
// Stalls: while out_ch is held off, the input register keeps one symbol and
//   in_ch.ready drops once both registers are full; nothing is lost.
// Reset (rst_n low, synchronous): registers return to their defaults, the bit
//   window and frame state clear and both channels empty. No clearing pass.
module hdlc_receive_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  hdlcrx_in_if.sink                          in_ch,
  hdlcrx_out_if.source                       out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hdlcrx_pkg::ADDR_W-1:0]      paddr,
  input  logic [hdlcrx_pkg::DATA_W-1:0]      pwdata,
  output logic [hdlcrx_pkg::DATA_W-1:0]      prdata,
  output logic                               pready
);

  // Configuration registers
  logic                              mode_r;
  logic                              hifirst_r;
  logic [hdlcrx_pkg::MAXL_W-1:0]     max_len_r;
  logic [hdlcrx_pkg::CRC_W-1:0]      crc_init_r;

  // Input register
  logic                              s1_valid_r;
  logic [hdlcrx_pkg::BYTE_W-1:0]     s1_data_r;
  logic                              s1_go;

  // Receive state
  logic [hdlcrx_pkg::BYTE_W-1:0]     win_r,   win_nxt;
  logic [hdlcrx_pkg::BYTE_W-1:0]     acc_r,   acc_nxt;
  logic [hdlcrx_pkg::CNT_W-1:0]      cnt_r,   cnt_nxt;
  logic [hdlcrx_pkg::BYTE_W-1:0]     hold0_r, hold0_nxt;
  logic [hdlcrx_pkg::BYTE_W-1:0]     hold1_r, hold1_nxt;
  logic [hdlcrx_pkg::POS_W-1:0]      pos_r,   pos_nxt;
  logic [hdlcrx_pkg::CRC_W-1:0]      crc_r,   crc_nxt;
  logic                              esc_r,   esc_nxt;

  // Decode results for the current symbol
  logic                              oct_vld;
  logic [hdlcrx_pkg::BYTE_W-1:0]     oct;
  logic [hdlcrx_pkg::BYTE_W-1:0]     ch;
  logic [hdlcrx_pkg::CRC_W-1:0]      rx_crc;
  logic                              res_vld;
  logic [hdlcrx_pkg::BYTE_W-1:0]     res_byte;
  logic                              res_end;
  hdlcrx_pkg::frame_status_t         res_stat;
  logic [hdlcrx_pkg::LEN_W-1:0]      res_len;

  // Output register
  logic                              out_valid_r;
  logic [hdlcrx_pkg::BYTE_W-1:0]     out_byte_r;
  logic                              out_end_r;
  hdlcrx_pkg::frame_status_t         out_stat_r;
  logic [hdlcrx_pkg::LEN_W-1:0]      out_len_r;

  logic                              cfg_wr;

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= hdlcrx_pkg::MODE_RST;
      hifirst_r  <= hdlcrx_pkg::HIFIRST_RST;
      max_len_r  <= hdlcrx_pkg::MAX_LEN_RST;
      crc_init_r <= hdlcrx_pkg::CRC_INIT_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        hdlcrx_pkg::REG_BITWISE_MODE:   mode_r     <= pwdata[0];
        hdlcrx_pkg::REG_CRC_HIGH_FIRST: hifirst_r  <= pwdata[0];
        hdlcrx_pkg::REG_MAX_FRAME_LEN:  max_len_r  <= pwdata[hdlcrx_pkg::MAXL_W-1:0];
        hdlcrx_pkg::REG_CRC_INIT:       crc_init_r <= pwdata[hdlcrx_pkg::CRC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      hdlcrx_pkg::REG_BITWISE_MODE:   prdata = hdlcrx_pkg::DATA_W'(mode_r);
      hdlcrx_pkg::REG_CRC_HIGH_FIRST: prdata = hdlcrx_pkg::DATA_W'(hifirst_r);
      hdlcrx_pkg::REG_MAX_FRAME_LEN:  prdata = hdlcrx_pkg::DATA_W'(max_len_r);
      hdlcrx_pkg::REG_CRC_INIT:       prdata = hdlcrx_pkg::DATA_W'(crc_init_r);
    endcase
  end

  // Handshake: the input register moves on when the output register can take
  // a result (empty or being drained this cycle)
  assign s1_go       = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_data_r <= in_ch.data_in;
    end
  end

  // Symbol decode, framing and CRC for the symbol in the input register
  always_comb begin
    win_nxt   = win_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    hold0_nxt = hold0_r;
    hold1_nxt = hold1_r;
    pos_nxt   = pos_r;
    crc_nxt   = crc_r;
    esc_nxt   = esc_r;
    oct_vld   = 1'b0;
    oct       = s1_data_r;
    ch        = s1_data_r;
    rx_crc    = hifirst_r ? {hold0_r, hold1_r} : {hold1_r, hold0_r};
    res_vld   = 1'b0;
    res_byte  = '0;
    res_end   = 1'b0;
    res_stat  = hdlcrx_pkg::ST_GOOD;
    res_len   = '0;

    // Bit mode: flag search, destuffing and octet assembly
    if (mode_r) begin
      win_nxt = {s1_data_r[0], win_r[7:1]};
      if (win_nxt == hdlcrx_pkg::FLAG_OCTET) begin
        acc_nxt = '0;
        cnt_nxt = '0;
        oct     = hdlcrx_pkg::FLAG_OCTET;
        oct_vld = 1'b1;
      end else if ((win_nxt & hdlcrx_pkg::STUFF_MASK) != hdlcrx_pkg::STUFF_PAT) begin
        acc_nxt = {s1_data_r[0], acc_r[7:1]};
        cnt_nxt = cnt_r + hdlcrx_pkg::CNT_W'(1);
        if (cnt_nxt >= hdlcrx_pkg::CNT_W'(8)) begin
          oct     = acc_nxt;
          acc_nxt = '0;
          cnt_nxt = '0;
          oct_vld = 1'b1;
        end
      end
    end else begin
      oct_vld = 1'b1;
    end

    // Octet handling
    if (oct_vld) begin
      if (oct == hdlcrx_pkg::FLAG_OCTET) begin
        // closing flag: check the two held bytes against the running CRC
        if (pos_r >= hdlcrx_pkg::POS_W'(2)) begin
          res_vld  = 1'b1;
          res_end  = 1'b1;
          res_stat = (rx_crc == crc_r) ? hdlcrx_pkg::ST_GOOD : hdlcrx_pkg::ST_CRC_ERR;
          res_len  = hdlcrx_pkg::LEN_W'(pos_r - hdlcrx_pkg::POS_W'(2));
        end
        pos_nxt = '0;
        esc_nxt = 1'b0;
        crc_nxt = crc_init_r;
      end else if (!esc_r && (oct == hdlcrx_pkg::ESC_OCTET)) begin
        esc_nxt = 1'b1;
      end else begin
        ch      = esc_r ? (oct ^ hdlcrx_pkg::ESC_XOR) : oct;
        esc_nxt = 1'b0;
        if ((pos_r >= max_len_r) || (pos_r == hdlcrx_pkg::POS_MASK)) begin
          // frame too long: abort and restart
          res_vld  = 1'b1;
          res_end  = 1'b1;
          res_stat = hdlcrx_pkg::ST_TOO_LONG;
          if (pos_r >= hdlcrx_pkg::POS_W'(2)) begin
            res_len = hdlcrx_pkg::LEN_W'(pos_r - hdlcrx_pkg::POS_W'(2));
          end
          pos_nxt = '0;
          crc_nxt = crc_init_r;
        end else begin
          // release the oldest held byte and fold it into the CRC
          if (pos_r >= hdlcrx_pkg::POS_W'(2)) begin
            crc_nxt  = hdlcrx_pkg::crc_step(crc_r, hold0_r);
            res_vld  = 1'b1;
            res_byte = hold0_r;
          end
          hold0_nxt = hold1_r;
          hold1_nxt = ch;
          pos_nxt   = pos_r + hdlcrx_pkg::POS_W'(1);
        end
      end
    end
  end

  // Receive state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
      acc_r <= '0;
      cnt_r <= '0;
      pos_r <= '0;
      crc_r <= hdlcrx_pkg::CRC_INIT_RST;
      esc_r <= 1'b0;
    end else if (s1_go) begin
      win_r <= win_nxt;
      acc_r <= acc_nxt;
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
      crc_r <= crc_nxt;
      esc_r <= esc_nxt;
    end
  end

  // Held bytes: read only after two writes in the same frame
  always_ff @(posedge clk) begin
    if (s1_go) begin
      hold0_r <= hold0_nxt;
      hold1_r <= hold1_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= res_vld;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_vld) begin
      out_byte_r <= res_byte;
      out_end_r  <= res_end;
      out_stat_r <= res_stat;
      out_len_r  <= res_len;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.out_byte     = out_byte_r;
  assign out_ch.frame_end    = out_end_r;
  assign out_ch.frame_status = out_stat_r;
  assign out_ch.payload_len  = out_len_r;

endmodule

/* design/hdlcrx_checker.sv */
// Port-level checks for hdlc_receive_deframer, attached by bind.
// Depends on hdlcrx_pkg and the top level's ports.
module hdlcrx_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [hdlcrx_pkg::BYTE_W-1:0]   out_byte,
  input logic                            out_frame_end,
  input logic [1:0]                      out_frame_status,
  input logic [hdlcrx_pkg::LEN_W-1:0]    out_payload_len
);

  // A stalled result request holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
    $stable(out_frame_end) && $stable(out_frame_status) && $stable(out_payload_len))
    else $error("result changed while stalled");

  // Payload bytes carry no status and no length
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_end |->
    (out_frame_status == hdlcrx_pkg::ST_GOOD) && (out_payload_len == '0))
    else $error("payload byte with status or length");

  // End requests carry a defined status and a zero byte
  a_end_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |->
    ((out_frame_status == hdlcrx_pkg::ST_GOOD) ||
     (out_frame_status == hdlcrx_pkg::ST_CRC_ERR) ||
     (out_frame_status == hdlcrx_pkg::ST_TOO_LONG)) && (out_byte == '0))
    else $error("bad end-of-frame request");

  // Reset empties the result channel
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind hdlc_receive_deframer hdlcrx_checker u_hdlcrx_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_byte         (out_ch.out_byte),
  .out_frame_end    (out_ch.frame_end),
  .out_frame_status (out_ch.frame_status),
  .out_payload_len  (out_ch.payload_len)
);
